@@ sv/pev_pkg.sv @@
`default_nettype none

package pev_pkg;

    // Coefficient register file and the number of terms in use
    localparam int NUM_COEFS  = 8;
    localparam int TERMS      = 8;
    localparam int USED_TERMS = (TERMS > NUM_COEFS) ? NUM_COEFS : ((TERMS < 1) ? 1 : TERMS);
    localparam int STEPS      = USED_TERMS - 1;
    localparam int COEF_IDX_W = $clog2(NUM_COEFS);

    // Q16.16 arithmetic
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int FRAC_BITS = 16;
    localparam int RND_W     = PROD_W - FRAC_BITS;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Three register stages per Horner step: multiply, round, add
    localparam int STAGES_PER_STEP = 3;
    localparam int NUM_STAGES      = STAGES_PER_STEP * STEPS;

    // Running value between Horner steps
    typedef struct packed {
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] x;
        logic                     ovf;
    } step_t;

    // Full product after the multiplier
    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic signed [DATA_W-1:0] x;
        logic                     ovf;
    } prod_t;

    // Rounded and saturated product
    typedef struct packed {
        logic signed [DATA_W-1:0] term;
        logic signed [DATA_W-1:0] x;
        logic                     ovf;
    } rnd_t;

endpackage

`default_nettype wire

@@ sv/pev_mul_stage.sv @@
`default_nettype none

module pev_mul_stage
    import pev_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire step_t in_data,
    output logic       out_valid,
    input  wire logic  out_stall,
    output prod_t      out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    // Hold while a valid item waits downstream
    assign in_stall = valid_reg & out_stall;

    // Form the exact product of the running value and the argument
    always_comb
    begin
        data_next.prod = in_data.acc * in_data.x;
        data_next.x    = in_data.x;
        data_next.ovf  = in_data.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ sv/pev_rnd_stage.sv @@
`default_nettype none

module pev_rnd_stage
    import pev_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire prod_t in_data,
    output logic       out_valid,
    input  wire logic  out_stall,
    output rnd_t       out_data
);

    logic                    valid_reg;
    rnd_t                    data_reg;
    rnd_t                    data_next;
    logic signed [RND_W-1:0] rounded;
    logic                    in_range;

    assign in_stall = valid_reg & out_stall;

    // Round to nearest, ties up: drop the fraction and add its top bit
    assign rounded = in_data.prod[PROD_W-1:FRAC_BITS]
                   + {{(RND_W-1){1'b0}}, in_data.prod[FRAC_BITS-1]};

    // In range when the result's sign bit and all bits above it agree
    assign in_range = (&rounded[RND_W-1:DATA_W-1]) | ~(|rounded[RND_W-1:DATA_W-1]);

    // Clamp to the 32-bit range and flag it
    always_comb
    begin
        if (in_range)
        begin
            data_next.term = rounded[DATA_W-1:0];
        end
        else if (rounded[RND_W-1])
        begin
            data_next.term = SAT_MIN;
        end
        else
        begin
            data_next.term = SAT_MAX;
        end
        data_next.x   = in_data.x;
        data_next.ovf = in_data.ovf | ~in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ sv/pev_add_stage.sv @@
`default_nettype none

module pev_add_stage
    import pev_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic signed [DATA_W-1:0] coef,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire rnd_t                     in_data,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output step_t                         out_data
);

    logic                  valid_reg;
    step_t                 data_reg;
    step_t                 data_next;
    logic signed [DATA_W:0] sum;
    logic                  sum_ovf;

    assign in_stall = valid_reg & out_stall;

    // Add the next lower coefficient with one guard bit
    assign sum     = {in_data.term[DATA_W-1], in_data.term} + {coef[DATA_W-1], coef};
    assign sum_ovf = sum[DATA_W] ^ sum[DATA_W-1];

    // Clamp and accumulate the sticky flag
    always_comb
    begin
        if (!sum_ovf)
        begin
            data_next.acc = sum[DATA_W-1:0];
        end
        else if (sum[DATA_W])
        begin
            data_next.acc = SAT_MIN;
        end
        else
        begin
            data_next.acc = SAT_MAX;
        end
        data_next.x   = in_data.x;
        data_next.ovf = in_data.ovf | sum_ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ sv/polynomial_evaluation_unit.sv @@
// Polynomial evaluation unit, signed Q16.16, Horner's rule, degree up to seven.
// Configuration: write coefficient i (x to the i-th) with cfg_we, cfg_index and
// cfg_data, only while no item is in flight. All coefficients reset to zero.
// Input channel: x_value with in_valid / in_stall; an item is taken on a clock
// edge with in_valid high and in_stall low.
// Output channel: poly_value and overflow with out_valid / out_stall; overflow
// is set when any Horner step saturated.
// Pipeline: a multiply, a round and an add register stage per Horner step, one step
// per used term beyond the first, between acceptance and out_valid.
// Throughput: one item per cycle while in_stall is low; each step has its own 32x32
// multiplier, so nothing is shared between items.
// Stall: each stage holds only while it is full and its successor holds, so
// bubbles collapse and new items are taken while a result waits at the output.
// in_stall rises only when every stage is full and out_stall is high.
// Reset: asynchronous, active low; empties the pipeline and clears coefficients.
`default_nettype none

module polynomial_evaluation_unit
    import pev_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [COEF_IDX_W-1:0]        cfg_index,
    input  wire logic [DATA_W-1:0]            cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [DATA_W-1:0]     x_value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [DATA_W-1:0]          poly_value,
    output logic                              overflow
);

    logic signed [DATA_W-1:0] coef_reg [NUM_COEFS];

    logic  s_valid [STEPS+1];
    logic  s_stall [STEPS+1];
    step_t s_data  [STEPS+1];
    logic  m_valid [STEPS];
    logic  m_stall [STEPS];
    prod_t m_data  [STEPS];
    logic  r_valid [STEPS];
    logic  r_stall [STEPS];
    rnd_t  r_data  [STEPS];

    logic [NUM_STAGES-1:0] stg_valid;

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Seed the running value with the highest used coefficient
    assign s_valid[0]     = in_valid;
    assign in_stall       = s_stall[0];
    assign s_data[0].acc  = coef_reg[USED_TERMS-1];
    assign s_data[0].x    = x_value;
    assign s_data[0].ovf  = 1'b0;

    // One multiply, round and add stage per Horner step
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        pev_mul_stage u_mul (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s_valid[k]),
            .in_stall  (s_stall[k]),
            .in_data   (s_data[k]),
            .out_valid (m_valid[k]),
            .out_stall (m_stall[k]),
            .out_data  (m_data[k])
        );

        pev_rnd_stage u_rnd (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (m_valid[k]),
            .in_stall  (m_stall[k]),
            .in_data   (m_data[k]),
            .out_valid (r_valid[k]),
            .out_stall (r_stall[k]),
            .out_data  (r_data[k])
        );

        pev_add_stage u_add (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef      (coef_reg[USED_TERMS-2-k]),
            .in_valid  (r_valid[k]),
            .in_stall  (r_stall[k]),
            .in_data   (r_data[k]),
            .out_valid (s_valid[k+1]),
            .out_stall (s_stall[k+1]),
            .out_data  (s_data[k+1])
        );

        assign stg_valid[STAGES_PER_STEP*k]     = m_valid[k];
        assign stg_valid[STAGES_PER_STEP*k + 1] = r_valid[k];
        assign stg_valid[STAGES_PER_STEP*k + 2] = s_valid[k+1];
    end

    // Last add stage is the output register
    assign out_valid       = s_valid[STEPS];
    assign s_stall[STEPS]  = out_stall;
    assign poly_value      = s_data[STEPS].acc;
    assign overflow        = s_data[STEPS].ovf;

    // Back-pressure reaches the input only from a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // Any empty stage lets a new item in
    a_bubble_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(&stg_valid) |-> !in_stall)
        else $error("input stalled while the pipeline has a bubble");

    // A held result keeps its overflow flag
    a_flag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (overflow == $past(overflow)))
        else $error("overflow flag changed on a held result");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import pev_pkg::*;

    // Cycles from acceptance to result, plus margin before a register write or the end
    localparam int LATENCY      = STAGES_PER_STEP * STEPS;
    localparam int DRAIN_CYCLES = LATENCY + 4;
    // Cycles with no item moving on either side before the run is abandoned
    localparam int QUIET_LIMIT  = 2000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 140;

    localparam logic [DATA_W-1:0] Q_ONE      = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_MINUS    = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] Q_HALF_ARG = 32'h0000_8000;
    localparam logic [DATA_W-1:0] ONE_LSB    = 32'h0000_0001;
    localparam logic [DATA_W-1:0] MINUS_LSB  = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] COEF_SPAN  = 32'h0004_0000;
    localparam logic [DATA_W-1:0] ARG_SPAN   = 32'h0002_0000;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     ovf;
    } poly_result_t;

    // Horner evaluation of the current coefficients; holds the values still due
    class poly_checker;
        logic signed [DATA_W-1:0] coef [NUM_COEFS];
        poly_result_t             due [$];
        int                       errors;

        function new();
            foreach (coef[i])
                coef[i] = '0;
            errors = 0;
        endfunction

        function void set_coef(input int idx, input logic [DATA_W-1:0] val);
            coef[idx] = val;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Clip to the signed 32-bit range, flag any change
        function logic signed [DATA_W-1:0] clip(input longint v, inout logic ovf);
            if (v > longint'(SAT_MAX))
            begin
                ovf = 1'b1;
                return SAT_MAX;
            end
            if (v < longint'(SAT_MIN))
            begin
                ovf = 1'b1;
                return SAT_MIN;
            end
            return v[DATA_W-1:0];
        endfunction

        // Evaluate at the accepted argument and queue the expected value
        function void note_argument(input logic signed [DATA_W-1:0] xv);
            poly_result_t             res;
            logic signed [DATA_W-1:0] acc;
            logic signed [DATA_W-1:0] term;
            longint                   prod;
            logic                     ovf;
            ovf = 1'b0;
            acc = coef[USED_TERMS-1];
            for (int i = USED_TERMS - 2; i >= 0; i--)
            begin
                prod = longint'(acc) * longint'(xv);
                // round to nearest, ties toward plus infinity
                term = clip((prod + 64'sd32768) >>> FRAC_BITS, ovf);
                acc  = clip(longint'(term) + longint'(coef[i]), ovf);
            end
            res.value = acc;
            res.ovf   = ovf;
            due.push_back(res);
        endfunction

        // Compare a delivered result with the oldest expected one
        function void check_value(input logic signed [DATA_W-1:0] val, input logic ovf);
            poly_result_t want;
            if (due.size() == 0)
            begin
                $error("poly_value %0d arrived with no item pending", val);
                errors++;
                return;
            end
            want = due.pop_front();
            if (val !== want.value)
            begin
                $error("poly_value: expected %0d, got %0d", want.value, val);
                errors++;
            end
            if (ovf !== want.ovf)
            begin
                $error("overflow: expected %0b, got %0b", want.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [COEF_IDX_W-1:0]    cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] x_value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] poly_value;
    logic                     overflow;

    poly_checker              book;
    logic [DATA_W-1:0]        coef_set [NUM_COEFS];
    int                       send_idle_pct;
    int                       out_stall_pct;
    int                       quiet;

    polynomial_evaluation_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_value    (x_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .poly_value (poly_value),
        .overflow   (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Track accepted items on both sides and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                book.note_argument(x_value);
            if (out_valid && !out_stall)
                book.check_value(poly_value, overflow);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Mostly small values so that results stay in range, with extremes mixed in
    function automatic logic [DATA_W-1:0] pick_value(input logic [DATA_W-1:0] span);
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // Write all coefficient registers from coef_set
    task automatic load_coefs();
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[COEF_IDX_W-1:0];
            cfg_data  <= coef_set[i];
            @(posedge clk);
            book.set_coef(i, coef_set[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item after a random gap; return at the edge that takes it
    task automatic send_item(input logic [DATA_W-1:0] xv);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            x_value  <= $urandom();
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_value  <= xv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [DATA_W-1:0] corner_args [6];
        int                degree;
        book          = new();
        send_idle_pct = 0;
        out_stall_pct = 0;
        corner_args   = '{'0, Q_ONE, Q_MINUS, Q_HALF_ARG, SAT_MAX, SAT_MIN};
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        x_value   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coefficients straight out of reset are all zero
        send_item(SAT_MAX);
        wait_idle();

        // Directed: all ones, all maximum, all minimum, alternating one LSB
        // (the last one hits rounding ties in both directions at x = 0.5)
        for (int s = 0; s < 4; s++)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                case (s)
                    0:       coef_set[i] = Q_ONE;
                    1:       coef_set[i] = SAT_MAX;
                    2:       coef_set[i] = SAT_MIN;
                    default: coef_set[i] = i[0] ? MINUS_LSB : ONE_LSB;
                endcase
            end
            load_coefs();
            foreach (corner_args[k])
                send_item(corner_args[k]);
            wait_idle();
        end

        // Random: new coefficients and degree each phase, cycling the idle modes
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin send_idle_pct = 66; out_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  out_stall_pct = 66; end
                default: begin send_idle_pct = 31; out_stall_pct = 31; end
            endcase
            degree = $urandom_range(0, NUM_COEFS - 1);
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                if (i > degree || $urandom_range(0, 7) == 0)
                    coef_set[i] = '0;
                else
                    coef_set[i] = pick_value(COEF_SPAN);
            end
            load_coefs();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off halfway until the pipeline has emptied
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                send_item(pick_value(ARG_SPAN));
            end
            wait_idle();
        end

        if (book.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
